FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/fme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fme_pkg: shared types, constants and AES helpers
// Holds the frame job record and the AES byte functions.
// ----------------------------------------------------------------------------
package fme_pkg;
  localparam int MAC_BYTES_DEF = 6;
  localparam logic [7:0] PAD_BYTE = 8'h55;
  localparam logic [7:0] CSUM_XOR2 = 8'h5B;
  localparam int NUM_ROUNDS = 10;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW = 1'b1;

  typedef struct packed {
    logic [127:0] block;
    logic [47:0]  rx_mac;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte i of a 128-bit word, byte 0 in the top bits.
  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction
endpackage

FILE: sv/fme_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fme_stream_if: valid/ready channel interfaces
// Frame byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface fme_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_byte;
  logic        action;
  logic [47:0] challenge;
  logic [15:0] sequence_req;
  logic [47:0] received_mac;
  modport source(output valid, data_byte, has_byte, last_byte, action, challenge,
                 sequence_req, received_mac, input ready);
  modport sink(input valid, data_byte, has_byte, last_byte, action, challenge,
               sequence_req, received_mac, output ready);
endinterface

interface fme_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] mac;
  logic        mac_matches;
  modport source(output valid, mac, mac_matches, input ready);
  modport sink(input valid, mac, mac_matches, output ready);
endinterface

interface fme_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/fme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fme_front: frame byte intake
// Updates checksum and prefix per byte; emits a block job on the last item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fme_front (
  input  logic           clk,
  input  logic           rst_n,
  fme_in_if.sink         in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output fme_pkg::job_t  job
);
  import fme_pkg::*;

  logic [7:0]  csum1_r, csum2_r, csum1_nxt, csum2_nxt;
  logic [63:0] prefix_r, prefix_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [7:0]  mixed, nx, sh;
  logic        acc;
  logic [127:0] blk;

  // Stall only when a job is offered and the queue is full.
  assign in_ch.ready = !(in_ch.last_byte && !job_ready);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    mixed = in_ch.data_byte ^ csum2_r;
    nx = {csum1_r[6:0], mixed[7]};
    sh = {mixed[6:0], 1'b0};
    csum1_nxt = csum1_r;
    csum2_nxt = csum2_r;
    prefix_nxt = prefix_r;
    seen_nxt = seen_r;
    if (in_ch.has_byte) begin
      csum1_nxt = csum1_r[7] ? (nx ^ PAD_BYTE) : nx;
      csum2_nxt = csum1_r[7] ? (sh ^ CSUM_XOR2) : sh;
      if (seen_r < 4'd8) begin
        prefix_nxt[63 - 8*seen_r[2:0] -: 8] = in_ch.data_byte;
        seen_nxt = seen_r + 4'd1;
      end
    end
  end

  always_comb begin
    blk = {prefix_nxt, csum1_nxt, csum2_nxt, in_ch.challenge};
    if (in_ch.action) begin
      blk[47:0] = {in_ch.sequence_req, {4{PAD_BYTE}}};
    end
  end

  assign job_valid = in_ch.valid && in_ch.last_byte;
  assign job.block = blk;
  assign job.rx_mac = in_ch.received_mac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum1_r <= '0;
      csum2_r <= '0;
      prefix_r <= {8{PAD_BYTE}};
      seen_r <= '0;
    end else if (acc) begin
      if (in_ch.last_byte) begin
        csum1_r <= '0;
        csum2_r <= '0;
        prefix_r <= {8{PAD_BYTE}};
        seen_r <= '0;
      end else begin
        csum1_r <= csum1_nxt;
        csum2_r <= csum2_nxt;
        prefix_r <= prefix_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  `ASSERT_IMPL(a_seen_sat, clk, rst_n, 1'b1, seen_r <= 4'd8)
  `ASSERT_NEXT(a_clear_after_last, clk, rst_n, acc && in_ch.last_byte, seen_r == 4'd0)
  `ASSERT_IMPL(a_job_only_last, clk, rst_n, job_valid, in_ch.last_byte)
endmodule

FILE: sv/fme_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fme_queue: two-entry job queue
// Decouples frame intake from the cipher engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fme_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  fme_pkg::job_t  wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output fme_pkg::job_t  rd_job
);
  import fme_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `ASSERT_IMPL(a_ptr_cnt, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r)
  `ASSERT_IMPL(a_ptr_one, clk, rst_n, cnt_r == 2'd1, wp_r != rp_r)
endmodule

FILE: sv/fme_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fme_cipher: iterative AES-128 engine with result register
// One round per cycle with on-the-fly key expansion, the last round held while a result waits; truncates to the MAC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fme_cipher #(
  parameter int MAC_BYTES = fme_pkg::MAC_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [127:0]   key,
  input  logic           job_valid,
  output logic           job_ready,
  input  fme_pkg::job_t  job,
  fme_out_if.source      out_ch
);
  import fme_pkg::*;

  localparam int MB = (MAC_BYTES < 6) ? MAC_BYTES : 6;
  localparam int SKIP = MAC_BYTES - MB;

  logic [127:0] st_r, rk_r, st_nxt, rk_nxt, ark;
  logic [47:0]  rx_r;
  logic [7:0]   rcon_r;
  logic [3:0]   rnd_r;
  logic         busy_r;
  logic [47:0]  mac_r;
  logic         match_r, ov_r, ov_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [7:0]   kw [4];
  logic [127:0] rnd_out;
  logic [47:0]  mac_cand;
  logic         finish;
  logic         hold;

  assign finish = busy_r && rnd_r == 4'(NUM_ROUNDS);
  assign job_ready = !busy_r;
  // Freeze the last round while the previous result still waits.
  assign hold = finish && ov_r && !out_ch.ready;

  always_comb begin
    ov_nxt = ov_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    if (finish && !hold) ov_nxt = 1'b1;
  end

  always_comb begin
    // Next round key.
    kw[0] = sbox(rk_r[23:16]) ^ rcon_r;
    kw[1] = sbox(rk_r[15:8]);
    kw[2] = sbox(rk_r[7:0]);
    kw[3] = sbox(rk_r[31:24]);
    rk_nxt[127:96] = rk_r[127:96] ^ {kw[0], kw[1], kw[2], kw[3]};
    rk_nxt[95:64] = rk_r[95:64] ^ rk_nxt[127:96];
    rk_nxt[63:32] = rk_r[63:32] ^ rk_nxt[95:64];
    rk_nxt[31:0] = rk_r[31:0] ^ rk_nxt[63:32];
    for (int i = 0; i < 16; i++) begin
      sb[i] = sbox(byte_at(st_r, i));
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r + 4*c] = sb[r + 4*((c + r) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mc[4*c]   = sr[4*c] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                  ^ xtime(sr[4*c] ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                  ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                  ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                  ^ xtime(sr[4*c+3] ^ sr[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      rnd_out[127 - 8*i -: 8] = (rnd_r == 4'(NUM_ROUNDS)) ? sr[i] : mc[i];
    end
    st_nxt = rnd_out ^ rk_nxt;
    ark = job.block ^ key;
    mac_cand = '0;
    for (int i = SKIP; i < MAC_BYTES; i++) begin
      mac_cand[47 - 8*(i - SKIP) -: 8] = byte_at(st_nxt, i);
    end
    mac_cand = mac_cand >> (8 * (6 - MB));
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      st_r <= ark;
      rk_r <= key;
      rx_r <= job.rx_mac;
    end else if (busy_r && !hold) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
    end
    if (finish && !hold) begin
      mac_r <= mac_cand;
      match_r <= mac_cand == rx_r;
    end
  end

  // Hold a finished round until the output register frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r <= 4'd1;
      rcon_r <= 8'h01;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (job_valid && job_ready) begin
        busy_r <= 1'b1;
        rnd_r <= 4'd1;
        rcon_r <= 8'h01;
      end else if (busy_r && !hold) begin
        if (finish) begin
          busy_r <= 1'b0;
        end else begin
          rnd_r <= rnd_r + 4'd1;
          rcon_r <= xtime(rcon_r);
        end
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.mac = mac_r;
  assign out_ch.mac_matches = match_r;

  `ASSERT_IMPL(a_rnd_range, clk, rst_n, busy_r, rnd_r >= 4'd1 && rnd_r <= 4'(NUM_ROUNDS))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(mac_r))
  `ASSERT_NEXT(a_start, clk, rst_n, job_valid && job_ready, busy_r && rnd_r == 4'd1)
endmodule

FILE: sv/frame_mac_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_mac_engine_top: frame checksum and truncated AES-128 MAC
// Front intake, two-entry job queue and iterative AES engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per transaction. has_byte marks a real byte,
//           last_byte closes the frame and launches one MAC computation.
//   out_* : one transaction per closed frame: mac and mac_matches.
//   cfg_* : key register writes (index 0 key_high, 1 key_low), always ready;
//           write only while the block is idle.
// Throughput: one byte transaction per cycle while in_ready is high. A closing
//   item is taken as long as the job queue has room; the AES engine runs one
//   round per cycle with on-the-fly key expansion, holding its last round while
//   a result waits; it takes a frame only once done, which sets the frame rate.
// Reset (synchronous, rst_n low): clears checksum, byte count, queue, engine and
//   key registers, and fills the prefix with pad bytes.
// Receiver stall: the result holds in the output register; the engine holds
//   its finished state, the queue fills, and then closing items stall in_ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module frame_mac_engine_top #(
  parameter int MAC_BYTES = fme_pkg::MAC_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fme_in_if.sink     in_ch,
  fme_out_if.source  out_ch,
  fme_cfg_if.sink    cfg_ch
);
  import fme_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        fq_valid, fq_ready, qc_valid, qc_ready;
  job_t        fq_job, qc_job;

  // Take register writes at any time.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY_HIGH: key_high_r <= cfg_ch.data;
        REG_KEY_LOW:  key_low_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  fme_front u_front (
    .clk, .rst_n, .in_ch,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  fme_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qc_valid), .rd_ready(qc_ready), .rd_job(qc_job)
  );

  fme_cipher #(.MAC_BYTES(MAC_BYTES)) u_cipher (
    .clk, .rst_n, .key({key_high_r, key_low_r}),
    .job_valid(qc_valid), .job_ready(qc_ready), .job(qc_job), .out_ch
  );

  `ASSERT_NEXT(a_key_write, clk, rst_n, cfg_ch.valid && cfg_ch.index == REG_KEY_HIGH,
    key_high_r == $past(cfg_ch.data))
  `ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ch.ready)
  `ASSERT_IMPL(a_last_stall, clk, rst_n, in_ch.valid && !in_ch.ready, in_ch.last_byte)
endmodule
